// File: src/swlap_pkg.sv
package swlap_pkg;

    localparam int LAP_W    = 32;
    localparam int SLOT_W   = 7;
    localparam int TENTHS_W = 26;
    localparam int HOURS_W  = 11;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int TEN_W    = 4;

    localparam logic [SLOT_W-1:0] LAST_SLOT = 7'd99;

    typedef enum logic [3:0] {
        ACT_TICK       = 4'd0,
        ACT_START_STOP = 4'd1,
        ACT_SPLIT      = 4'd2,
        ACT_RESET      = 4'd3,
        ACT_ENTER      = 4'd4,
        ACT_UP         = 4'd5,
        ACT_DOWN       = 4'd6,
        ACT_DIGIT      = 4'd7,
        ACT_BACKSPACE  = 4'd8,
        ACT_ADD_TIME   = 4'd9
    } action_t;

    typedef struct packed {
        logic [LAP_W-1:0]  lap;
        logic [LAP_W-1:0]  total;
        logic              running;
        logic [SLOT_W-1:0] slot;
        logic              pending;
        logic              store;
        logic [SLOT_W-1:0] store_slot;
    } side_t;

    typedef struct packed {
        logic [TENTHS_W-1:0] tenths_total;
        logic [HOURS_W-1:0]  hours;
        logic [MIN_W-1:0]    minutes;
        logic [SEC_W-1:0]    seconds;
        logic [TEN_W-1:0]    tenths;
    } hms_t;

endpackage

// File: src/swlap_hms.sv
module swlap_hms
    import swlap_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [LAP_W-1:0] x,
    input  logic             clr,
    output hms_t             hms
);

    localparam logic [31:0] MUL_D100  = 32'h51EB851F;
    localparam logic [25:0] MUL_D10   = 26'd53687092;
    localparam logic [22:0] MUL_D60_S = 23'd4473925;
    localparam logic [17:0] MUL_D60_M = 18'd139811;

    logic [63:0] prod_a;
    logic [51:0] prod_b;
    logic [44:0] prod_c;
    logic [34:0] prod_d;
    logic [25:0] ten_c;
    logic [22:0] sec_d;
    logic [16:0] min_e;

    logic [25:0] q1_a_reg, q1_b_reg, q1_c_reg, q1_d_reg;
    logic        clr_a_reg, clr_b_reg, clr_c_reg, clr_d_reg;
    logic [22:0] s_b_reg, s_c_reg;
    logic [16:0] m_c_reg, m_d_reg;
    logic [3:0]  ten_c_reg, ten_d_reg;
    logic [5:0]  sec_d_reg;
    logic [10:0] hrs_d_reg;
    hms_t        hms_reg;

    assign prod_a = 64'(x) * 64'(MUL_D100);
    assign prod_b = 52'(q1_a_reg) * 52'(MUL_D10);
    assign prod_c = 45'(s_b_reg) * 45'(MUL_D60_S);
    assign ten_c  = q1_b_reg - 26'(s_b_reg) * 26'd10;
    assign prod_d = 35'(m_c_reg) * 35'(MUL_D60_M);
    assign sec_d  = s_c_reg - 23'(m_c_reg) * 23'd60;
    assign min_e  = m_d_reg - 17'(hrs_d_reg) * 17'd60;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_a_reg  <= prod_a[62:37];
            clr_a_reg <= clr;

            q1_b_reg  <= q1_a_reg;
            s_b_reg   <= prod_b[51:29];
            clr_b_reg <= clr_a_reg;

            q1_c_reg  <= q1_b_reg;
            s_c_reg   <= s_b_reg;
            m_c_reg   <= prod_c[44:28];
            ten_c_reg <= ten_c[3:0];
            clr_c_reg <= clr_b_reg;

            q1_d_reg  <= q1_c_reg;
            m_d_reg   <= m_c_reg;
            ten_d_reg <= ten_c_reg;
            sec_d_reg <= sec_d[5:0];
            hrs_d_reg <= prod_d[33:23];
            clr_d_reg <= clr_c_reg;

            hms_reg.tenths_total <= q1_d_reg;
            hms_reg.hours        <= clr_d_reg ? '0 : hrs_d_reg;
            hms_reg.minutes      <= clr_d_reg ? '0 : min_e[5:0];
            hms_reg.seconds      <= clr_d_reg ? '0 : sec_d_reg;
            hms_reg.tenths       <= clr_d_reg ? '0 : ten_d_reg;
        end
    end

    assign hms = hms_reg;

endmodule

// File: src/stopwatch_lap_split_register_select.sv
// Throughput: one word per cycle; the whole pipeline holds while the output
// word waits, and the input is taken whenever the output stage is empty or being read.
// The lap breakdown runs through four constant multipliers, one per stage.
// Reset (rst_n low, asynchronous) stops the watch, clears lap, total, slot
// and digit entry, and empties the pipeline.
module stopwatch_lap_split_register_select
    import swlap_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // digit[3:0], add_ms[35:4], zero[39:36]
    input  logic [3:0]   s_axis_tuser,  // action[3:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,  // lap_ms, total_ms, running, slot_index,
                                        // digit_pending, store_slot, store_tenths,
                                        // show_hours, show_minutes, show_seconds,
                                        // show_tenths, zero pad
    output logic [0:0]   m_axis_tuser   // store_valid
);

    localparam int DEPTH = 6;

    action_t           act;
    logic [3:0]        dig;
    logic [LAP_W-1:0]  add;
    logic              en, accept;

    logic              run_reg, run_next;
    logic [LAP_W-1:0]  lap_reg, lap_next;
    logic [LAP_W-1:0]  total_reg, total_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              pend_reg, pend_next;
    logic [3:0]        first_reg, first_next;

    logic              store, split_store;
    logic [SLOT_W-1:0] slot_up, slot_dn, typed_slot, first_slot;
    logic [7:0]        typed;

    logic [DEPTH-1:0]  vld_reg;
    side_t             side_next;
    side_t             side_reg [DEPTH];
    logic [LAP_W-1:0]  x_reg;
    logic              clr_reg;
    hms_t              hms;
    side_t             res;

    assign act = action_t'(s_axis_tuser);
    assign dig = s_axis_tdata[3:0];
    assign add = s_axis_tdata[35:4];

    assign en            = !vld_reg[DEPTH-1] || m_axis_tready;
    assign accept        = s_axis_tvalid && en;
    assign s_axis_tready = en;

    assign slot_up    = (slot_reg >= LAST_SLOT) ? '0 : slot_reg + 7'd1;
    assign slot_dn    = (slot_reg == '0 || slot_reg > LAST_SLOT) ? LAST_SLOT
                                                                 : slot_reg - 7'd1;
    assign typed      = 8'(first_reg) * 8'd10 + 8'(dig);
    assign typed_slot = (typed > 8'(LAST_SLOT)) ? LAST_SLOT : typed[6:0];
    assign first_slot = (7'(first_reg) > LAST_SLOT) ? LAST_SLOT : 7'(first_reg);

    always_comb
    begin
        run_next    = run_reg;
        lap_next    = lap_reg;
        total_next  = total_reg;
        slot_next   = slot_reg;
        pend_next   = pend_reg;
        first_next  = first_reg;
        store       = 1'b0;
        split_store = 1'b0;
        case (act)
            ACT_TICK:
            begin
                if (run_reg)
                begin
                    lap_next = lap_reg + 32'd1;
                    if (total_reg != '0)
                        total_next = total_reg + 32'd1;
                end
            end
            ACT_START_STOP:
            begin
                run_next  = !run_reg;
                pend_next = 1'b0;
            end
            ACT_SPLIT, ACT_ENTER:
            begin
                if (!pend_reg)
                begin
                    store     = 1'b1;
                    slot_next = slot_up;
                    if (act == ACT_SPLIT)
                    begin
                        split_store = 1'b1;
                        if (total_reg == '0)
                            total_next = lap_reg;
                        lap_next = '0;
                    end
                end
                else if (act == ACT_ENTER)
                begin
                    pend_next = 1'b0;
                    slot_next = first_slot;
                end
            end
            ACT_RESET:
            begin
                lap_next   = '0;
                total_next = '0;
                pend_next  = 1'b0;
            end
            ACT_UP:
            begin
                slot_next = slot_up;
                pend_next = 1'b0;
            end
            ACT_DOWN:
            begin
                slot_next = slot_dn;
                pend_next = 1'b0;
            end
            ACT_DIGIT:
            begin
                if (!pend_reg)
                begin
                    pend_next  = 1'b1;
                    first_next = dig;
                end
                else
                begin
                    pend_next = 1'b0;
                    slot_next = typed_slot;
                end
            end
            ACT_BACKSPACE:
            begin
                pend_next = 1'b0;
                if (!pend_reg)
                begin
                    lap_next   = '0;
                    total_next = '0;
                end
            end
            ACT_ADD_TIME:
                lap_next = lap_reg + add;
            default:
                ;
        endcase
    end

    always_comb
    begin
        side_next.lap        = lap_next;
        side_next.total      = total_next;
        side_next.running    = run_next;
        side_next.slot       = slot_next;
        side_next.pending    = pend_next;
        side_next.store      = store;
        side_next.store_slot = store ? slot_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            lap_reg   <= '0;
            total_reg <= '0;
            slot_reg  <= '0;
            pend_reg  <= 1'b0;
            first_reg <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                run_reg   <= run_next;
                lap_reg   <= lap_next;
                total_reg <= total_next;
                slot_reg  <= slot_next;
                pend_reg  <= pend_next;
                first_reg <= first_next;
            end
            if (en)
                vld_reg <= {vld_reg[DEPTH-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            x_reg       <= split_store ? lap_reg : lap_next;
            clr_reg     <= split_store;
            for (int i = 1; i < DEPTH; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    swlap_hms u_hms (
        .clk (clk),
        .en  (en),
        .x   (x_reg),
        .clr (clr_reg),
        .hms (hms)
    );

    assign res           = side_reg[DEPTH-1];
    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tuser  = res.store;
    assign m_axis_tdata  = {3'b000,
                            hms.tenths,
                            hms.seconds,
                            hms.minutes,
                            hms.hours,
                            res.store ? hms.tenths_total : 26'd0,
                            res.store_slot,
                            res.pending,
                            res.slot,
                            res.running,
                            res.total,
                            res.lap};

`ifndef SYNTH
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("selected slot beyond last slot");

    a_tick_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        accept && act == ACT_TICK && !run_reg |=> $stable(lap_reg))
        else $error("lap advanced while stopped");

    a_split_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && act == ACT_SPLIT && !pend_reg |=> lap_reg == '0)
        else $error("split left lap uncleared");

    a_show_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> hms.tenths <= 4'd9 && hms.seconds <= 6'd59
                          && hms.minutes <= 6'd59)
        else $error("lap breakdown out of range");
`endif

endmodule

// File: tb/stopwatch_lap_split_register_select_tb.sv
`timescale 1ns / 100ps

module stopwatch_lap_split_register_select_tb;
    import swlap_pkg::*;

    localparam int unsigned MS_PER_HOUR   = 32'd3600000;
    localparam int unsigned MS_PER_MINUTE = 32'd60000;
    localparam int unsigned MS_PER_SECOND = 32'd1000;
    localparam int unsigned MS_PER_TENTH  = 32'd100;
    localparam logic [3:0]  ACT_SPARE_LO  = 4'd10;
    localparam logic [3:0]  ACT_SPARE_HI  = 4'd15;
    localparam int          PIPE_DEPTH    = 6;
    localparam int          MAX_GAP       = 11;
    localparam longint      CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [LAP_W-1:0]    lap;
        logic [LAP_W-1:0]    total;
        logic                running;
        logic [SLOT_W-1:0]   slot;
        logic                pending;
        logic                store;
        logic [SLOT_W-1:0]   store_slot;
        logic [TENTHS_W-1:0] store_tenths;
        logic [HOURS_W-1:0]  hours;
        logic [MIN_W-1:0]    minutes;
        logic [SEC_W-1:0]    seconds;
        logic [TEN_W-1:0]    tenths;
    } readout_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic [3:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    logic              w_running;
    logic [LAP_W-1:0]  w_lap;
    logic [LAP_W-1:0]  w_total;
    logic [SLOT_W-1:0] w_slot;
    logic              w_pending;
    logic [3:0]        w_first_digit;

    readout_t pending_readouts[$];
    bit       no_gaps = 1'b0;
    int       words_sent = 0;
    int       words_checked = 0;
    int       stores_seen = 0;
    int       mismatches = 0;
    int       strays = 0;
    longint   cycle_count = 0;

    stopwatch_lap_split_register_select DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_readouts.size());
            $display("stopwatch_lap_split_register_select verification failed");
            $finish;
        end
    end

    function automatic logic [SLOT_W-1:0] clamp_slot(int unsigned v);
        return (v > LAST_SLOT) ? LAST_SLOT : v[SLOT_W-1:0];
    endfunction

    function automatic void watch_clear();
        w_running     = 1'b0;
        w_lap         = '0;
        w_total       = '0;
        w_slot        = '0;
        w_pending     = 1'b0;
        w_first_digit = '0;
    endfunction

    function automatic void step_slot_up();
        w_slot    = (w_slot >= LAST_SLOT) ? '0 : w_slot + 1'b1;
        w_pending = 1'b0;
    endfunction

    function automatic readout_t advance_watch(logic [3:0] act, logic [3:0] dig,
                                               logic [31:0] add);
        readout_t r;
        r.store        = 1'b0;
        r.store_slot   = '0;
        r.store_tenths = '0;
        case (act)
            ACT_TICK:
            begin
                if (w_running)
                begin
                    w_lap = w_lap + 1'b1;
                    if (w_total != 0)
                        w_total = w_total + 1'b1;
                end
            end
            ACT_START_STOP:
            begin
                w_running = ~w_running;
                w_pending = 1'b0;
            end
            ACT_SPLIT, ACT_ENTER:
            begin
                if (!w_pending)
                begin
                    r.store        = 1'b1;
                    r.store_slot   = w_slot;
                    r.store_tenths = TENTHS_W'(w_lap / MS_PER_TENTH);
                    step_slot_up();
                    if (act == ACT_SPLIT)
                    begin
                        if (w_total == 0)
                            w_total = w_lap;
                        w_lap = '0;
                    end
                end
                else if (act == ACT_ENTER)
                begin
                    w_pending = 1'b0;
                    w_slot    = clamp_slot(32'(w_first_digit));
                end
            end
            ACT_RESET:
            begin
                w_lap     = '0;
                w_total   = '0;
                w_pending = 1'b0;
            end
            ACT_UP:
                step_slot_up();
            ACT_DOWN:
            begin
                w_slot    = (w_slot == 0 || w_slot > LAST_SLOT) ? LAST_SLOT : w_slot - 1'b1;
                w_pending = 1'b0;
            end
            ACT_DIGIT:
            begin
                if (!w_pending)
                begin
                    w_pending     = 1'b1;
                    w_first_digit = dig;
                end
                else
                begin
                    w_pending = 1'b0;
                    w_slot    = clamp_slot(w_first_digit * 10 + dig);
                end
            end
            ACT_BACKSPACE:
            begin
                if (w_pending)
                    w_pending = 1'b0;
                else
                begin
                    w_lap   = '0;
                    w_total = '0;
                end
            end
            ACT_ADD_TIME:
                w_lap = w_lap + add;
            default:
            begin
            end
        endcase
        r.lap     = w_lap;
        r.total   = w_total;
        r.running = w_running;
        r.slot    = w_slot;
        r.pending = w_pending;
        r.hours   = HOURS_W'(w_lap / MS_PER_HOUR);
        r.minutes = MIN_W'(w_lap % MS_PER_HOUR / MS_PER_MINUTE);
        r.seconds = SEC_W'(w_lap % MS_PER_MINUTE / MS_PER_SECOND);
        r.tenths  = TEN_W'(w_lap % MS_PER_SECOND / MS_PER_TENTH);
        return r;
    endfunction

    task automatic press(logic [3:0] act, logic [3:0] dig, logic [31:0] add);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, add, dig};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_readouts.push_back(advance_watch(act, dig, add));
        words_sent++;
    endtask

    task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d: %s expected %0d, got %0d",
                         words_checked, name, want, got);
        end
    endtask

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        readout_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_readouts.size() == 0)
            begin
                strays++;
                $display("word with no prediction waiting: %h", m_axis_tdata);
            end
            else
            begin
                want = pending_readouts.pop_front();
                note_field("lap_ms",        want.lap,          m_axis_tdata[31:0]);
                note_field("total_ms",      want.total,        m_axis_tdata[63:32]);
                note_field("running",       32'(want.running), 32'(m_axis_tdata[64]));
                note_field("slot_index",    32'(want.slot),    32'(m_axis_tdata[71:65]));
                note_field("digit_pending", 32'(want.pending), 32'(m_axis_tdata[72]));
                note_field("store_slot",    32'(want.store_slot),
                           32'(m_axis_tdata[79:73]));
                note_field("store_tenths",  32'(want.store_tenths),
                           32'(m_axis_tdata[105:80]));
                note_field("show_hours",    32'(want.hours),   32'(m_axis_tdata[116:106]));
                note_field("show_minutes",  32'(want.minutes), 32'(m_axis_tdata[122:117]));
                note_field("show_seconds",  32'(want.seconds), 32'(m_axis_tdata[128:123]));
                note_field("show_tenths",   32'(want.tenths),  32'(m_axis_tdata[132:129]));
                note_field("store_valid",   32'(want.store),   32'(m_axis_tuser[0]));
                if (want.store)
                    stores_seen++;
                words_checked++;
            end
        end
    end

    task automatic test_counting();
        press(ACT_TICK, 4'd0, 32'd0);
        press(ACT_SPARE_HI, 4'd9, 32'hFFFF_FFFF);
        press(ACT_SPARE_LO, 4'd0, 32'd0);
        press(ACT_START_STOP, 4'd0, 32'd0);
        press(ACT_TICK, 4'd0, 32'd0);
        press(ACT_ADD_TIME, 4'd0, 32'hFFFF_FFFE);
        press(ACT_TICK, 4'd0, 32'd0);
        press(ACT_ADD_TIME, 4'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_store_and_split();
        press(ACT_ENTER, 4'd0, 32'd0);
        press(ACT_SPLIT, 4'd0, 32'd0);
        press(ACT_TICK, 4'd0, 32'd0);
        press(ACT_ADD_TIME, 4'd0, 32'd3599999);
        press(ACT_SPLIT, 4'd0, 32'd0);
    endtask

    task automatic test_slot_entry();
        press(ACT_DIGIT, 4'd9, 32'd0);
        press(ACT_SPLIT, 4'd0, 32'd0);
        press(ACT_ENTER, 4'd0, 32'd0);
        press(ACT_DIGIT, 4'd9, 32'd0);
        press(ACT_DIGIT, 4'd9, 32'd0);
        press(ACT_UP, 4'd0, 32'd0);
        press(ACT_DOWN, 4'd0, 32'd0);
        press(ACT_DIGIT, 4'd8, 32'd0);
        press(ACT_DIGIT, 4'd0, 32'd0);
    endtask

    task automatic test_clearing();
        press(ACT_DIGIT, 4'd5, 32'd0);
        press(ACT_BACKSPACE, 4'd0, 32'd0);
        press(ACT_BACKSPACE, 4'd0, 32'd0);
        press(ACT_ADD_TIME, 4'd0, 32'd61234);
        press(ACT_RESET, 4'd0, 32'd0);
        press(ACT_START_STOP, 4'd0, 32'd0);
    endtask

    function automatic logic [31:0] random_amount();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 5000);
            1:       return $urandom_range(0, 4000000);
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 300);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] random_digit();
        return 4'($urandom_range(0, 9));
    endfunction

    function automatic logic [3:0] random_action();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) return ACT_TICK;
        if (pick < 30) return ACT_START_STOP;
        if (pick < 38) return ACT_SPLIT;
        if (pick < 42) return ACT_RESET;
        if (pick < 50) return ACT_ENTER;
        if (pick < 56) return ACT_UP;
        if (pick < 62) return ACT_DOWN;
        if (pick < 78) return ACT_DIGIT;
        if (pick < 83) return ACT_BACKSPACE;
        if (pick < 96) return ACT_ADD_TIME;
        return 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    endfunction

    task automatic test_random_events(int count);
        for (int i = 0; i < count; i++)
        begin
            no_gaps = (i % 300) >= 240;
            press(random_action(), random_digit(), random_amount());
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_entry_sequences(int count);
        int shape;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                press(ACT_START_STOP, 4'd0, 32'd0);
            repeat ($urandom_range(0, 3))
                press(ACT_TICK, 4'd0, 32'd0);
            if ($urandom_range(0, 1))
                press(ACT_ADD_TIME, 4'd0, random_amount());
            shape = $urandom_range(0, 9);
            press(ACT_DIGIT, random_digit(), 32'd0);
            if (shape < 5)
                press(ACT_DIGIT, random_digit(), 32'd0);
            else if (shape < 7)
                press(ACT_ENTER, 4'd0, 32'd0);
            else if (shape < 8)
                press(ACT_BACKSPACE, 4'd0, 32'd0);
            else
                press(ACT_SPLIT, 4'd0, 32'd0);
            case ($urandom_range(0, 4))
                0:       press(ACT_SPLIT, 4'd0, 32'd0);
                1:       press(ACT_ENTER, 4'd0, 32'd0);
                2:       press(ACT_UP, 4'd0, 32'd0);
                3:       press(ACT_DOWN, 4'd0, 32'd0);
                default: press(random_action(), random_digit(), random_amount());
            endcase
        end
    endtask

    initial
    begin
        watch_clear();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_counting();
        test_store_and_split();
        test_slot_entry();
        test_clearing();
        test_random_events(900);
        test_entry_sequences(150);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (3 * PIPE_DEPTH) @(posedge clk);

        $display("sent %0d words, checked %0d results, %0d of them lap stores",
                 words_sent, words_checked, stores_seen);
        $display("%0d field mismatches, %0d unexpected words", mismatches, strays);
        if (mismatches == 0 && strays == 0 && pending_readouts.size() == 0)
            $display("stopwatch_lap_split_register_select verification clean");
        else
            $display("stopwatch_lap_split_register_select verification failed");
        $finish;
    end

endmodule
